// ----- src/text_console_char_writer_macros.svh -----
// Assertion macros for the text console character writer.
// Used by the engine module; no other dependencies.
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold after the non-overlapping implication and a further cycle delay operator.
`define TCW_ASSERT_NEXT2(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
      else $error(msg);

`endif

// ----- src/tcw_pkg.sv -----
// Shared constants, codes and types for the text console character writer.
// No dependencies.
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int CELL_AW    = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);

   // item field widths
   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int CELL_W     = 16;
   localparam int INDEX_W    = 11;
   localparam int ROW_OUT_W  = 5;
   localparam int COL_OUT_W  = 7;

   // register port
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int REG_IDX_W  = CSR_AW - 2;
   localparam logic [REG_IDX_W-1:0] REG_TEXT_COLOR = REG_IDX_W'(0);
   localparam logic [COLOR_W-1:0]   COLOR_RESET    = COLOR_W'(7);

   // item opcodes
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // character and cell codes
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
   localparam logic [CHAR_W-1:0] SPACE_CODE   = CHAR_W'(32);
   localparam logic [CELL_W-1:0] BLANK_CELL   = CELL_W'(16'h0720);

   // screen store access request
   typedef struct packed {
      logic               wr_en;
      logic [CELL_AW-1:0] wr_addr;
      logic [CELL_W-1:0]  wr_data;
      logic               rd_en;
      logic [CELL_AW-1:0] rd_addr;
   } ram_req_type;

   function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                   input logic [COLOR_W-1:0] color);
      make_cell = {color, ch};
   endfunction

endpackage

// ----- src/text_console_char_writer.sv -----
// Top level of the text console character writer.
// Depends on tcw_pkg, tcw_csr, tcw_screen_ram and tcw_engine.
//
// Usage:
//   Items enter on start/req_* and are taken at a clock edge where start is
//   high and busy is low. Each item gives one result, shown on rsp_* for one
//   cycle with rsp_strobe high; the receiver cannot stall it.
//   Put item that does not scroll (newline too): result the cycle after the
//   accept, busy stays low, so puts run at one item per cycle.
//   Read item: busy for one cycle; the screen store's registered read port
//   returns the cell in ST_READ, where the result register takes it.
//   Put or newline that scrolls: busy through the copy and fill sweeps. The
//   screen store's separate read and write ports move one cell per cycle up
//   a row, then one cell per cycle fills the last row; the result comes
//   out in the cycle busy drops.
//   Reset: a clearing pass writes every cell to blank, one cell a cycle,
//   with busy high. The colour register is reset to light grey on black
//   and may be written on the APB port at any time.
module text_console_char_writer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_read_index,
   output logic                          rsp_strobe,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_cell_entry,
   output logic [tcw_pkg::ROW_OUT_W-1:0] rsp_cursor_row_out,
   output logic [tcw_pkg::COL_OUT_W-1:0] rsp_cursor_column_out,
   output logic                          rsp_scrolled,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tcw_pkg::CSR_AW-1:0]    paddr,
   input  logic [tcw_pkg::CSR_DW-1:0]    pwdata,
   output logic [tcw_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   logic [tcw_pkg::COLOR_W-1:0] text_color;
   tcw_pkg::ram_req_type        ram_req;
   logic [tcw_pkg::CELL_W-1:0]  rd_data;

   // colour register
   tcw_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .text_color (text_color)
   );

   // screen store
   tcw_screen_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // sequencer
   tcw_engine u_engine (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_char_code         (req_char_code),
      .req_read_index        (req_read_index),
      .text_color            (text_color),
      .ram_req               (ram_req),
      .rd_data               (rd_data),
      .rsp_strobe            (rsp_strobe),
      .rsp_cell_entry        (rsp_cell_entry),
      .rsp_cursor_row_out    (rsp_cursor_row_out),
      .rsp_cursor_column_out (rsp_cursor_column_out),
      .rsp_scrolled          (rsp_scrolled)
   );

endmodule

// ----- src/tcw_screen_ram.sv -----
// Screen store: one write port, one read port with registered read data.
// Depends on tcw_pkg.
module tcw_screen_ram (
   input  logic                      clock,
   input  tcw_pkg::ram_req_type      ram_req,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);

   logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
   logic [tcw_pkg::CELL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tcw_csr.sv -----
// Register port: holds the text colour, written and read over an APB-style bus.
// Depends on tcw_pkg.
module tcw_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tcw_pkg::CSR_AW-1:0]  paddr,
   input  logic [tcw_pkg::CSR_DW-1:0]  pwdata,
   output logic [tcw_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output logic [tcw_pkg::COLOR_W-1:0] text_color
);

   logic [tcw_pkg::COLOR_W-1:0]   text_color_ff;
   logic [tcw_pkg::REG_IDX_W-1:0] reg_idx;
   logic                          wr_fire;

   assign reg_idx = paddr[tcw_pkg::CSR_AW-1:2];
   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite;

   // colour register; writes to other indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= tcw_pkg::COLOR_RESET;
      end else if (wr_fire && reg_idx == tcw_pkg::REG_TEXT_COLOR) begin
         text_color_ff <= pwdata[tcw_pkg::COLOR_W-1:0];
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         tcw_pkg::REG_TEXT_COLOR: prdata = tcw_pkg::CSR_DW'(text_color_ff);
         default:                 prdata = '0;
      endcase
   end

   assign text_color = text_color_ff;

endmodule

// ----- src/tcw_engine.sv -----
// Sequencer for the console: cursor tracking, put/read items, and the address
// counters (dst_ff shared by all) that drive the clear, scroll copy and row fill sweeps.
// Depends on tcw_pkg and text_console_char_writer_macros.svh.
`include "text_console_char_writer_macros.svh"

module tcw_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_read_index,
   input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
   output tcw_pkg::ram_req_type          ram_req,
   input  logic [tcw_pkg::CELL_W-1:0]    rd_data,
   output logic                          rsp_strobe,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_cell_entry,
   output logic [tcw_pkg::ROW_OUT_W-1:0] rsp_cursor_row_out,
   output logic [tcw_pkg::COL_OUT_W-1:0] rsp_cursor_column_out,
   output logic                          rsp_scrolled
);

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_COPY, ST_FILL} state_type;

   state_type                        state_ff;
   logic [tcw_pkg::ROW_W-1:0]        row_ff;
   logic [tcw_pkg::COL_W-1:0]        col_ff;
   logic [tcw_pkg::CELL_AW-1:0]      row_base_ff;
   logic [tcw_pkg::CNT_W-1:0]        src_ff;
   logic [tcw_pkg::CNT_W-1:0]        dst_ff;
   logic                             rd_valid_ff;
   logic                             scroll_ff;
   logic                             oob_ff;
   logic [tcw_pkg::CELL_W-1:0]       fill_ff;
   logic                             strobe_ff;
   logic [tcw_pkg::CELL_W-1:0]       cell_ff;
   logic [tcw_pkg::ROW_OUT_W-1:0]    row_out_ff;
   logic [tcw_pkg::COL_OUT_W-1:0]    col_out_ff;
   logic                             scrolled_ff;

   logic                             accept;
   logic                             is_put;
   logic                             is_newline;
   logic [tcw_pkg::COL_W:0]          col_inc;
   logic                             wrap;
   logic                             last_row;
   logic                             do_scroll;
   logic                             in_range;
   logic                             src_live;
   logic [tcw_pkg::ROW_W-1:0]        row_in;
   logic [tcw_pkg::COL_W-1:0]        col_in;
   logic [tcw_pkg::CELL_AW-1:0]      row_base_in;
   logic [tcw_pkg::CELL_W-1:0]       new_cell;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign is_put     = accept && req_opcode == tcw_pkg::OP_PUT;
   assign is_newline = (req_char_code == tcw_pkg::NEWLINE_CODE);
   assign new_cell   = tcw_pkg::make_cell(req_char_code, text_color);
   assign in_range   = (32'(req_read_index) < 32'(tcw_pkg::CELL_COUNT));
   assign src_live   = (src_ff < tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT));

   // next cursor position for a put item
   always_comb begin
      col_inc     = {1'b0, col_ff} + (tcw_pkg::COL_W + 1)'(1);
      wrap        = is_newline || col_inc == (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS);
      last_row    = (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
      do_scroll   = is_put && wrap && last_row;
      row_in      = row_ff;
      row_base_in = row_base_ff;
      col_in      = col_inc[tcw_pkg::COL_W-1:0];
      if (wrap) begin
         col_in = '0;
         if (!last_row) begin
            row_in      = row_ff + tcw_pkg::ROW_W'(1);
            row_base_in = row_base_ff + tcw_pkg::CELL_AW'(tcw_pkg::COLUMNS);
         end
      end
   end

   // screen store requests
   always_comb begin
      ram_req = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_put && !is_newline) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = row_base_ff + tcw_pkg::CELL_AW'(col_ff);
               ram_req.wr_data = new_cell;
            end
            if (accept && req_opcode == tcw_pkg::OP_READ) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = in_range ? tcw_pkg::CELL_AW'(req_read_index) : '0;
            end
         end
         ST_READ: begin
            ram_req = '0;
         end
         ST_COPY: begin
            ram_req.rd_en   = src_live;
            ram_req.rd_addr = src_ff[tcw_pkg::CELL_AW-1:0];
            ram_req.wr_en   = rd_valid_ff;
            ram_req.wr_addr = dst_ff[tcw_pkg::CELL_AW-1:0];
            ram_req.wr_data = rd_data;
         end
         ST_FILL: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = dst_ff[tcw_pkg::CELL_AW-1:0];
            ram_req.wr_data = fill_ff;
         end
         default: ram_req = '0;
      endcase
   end

   // state, cursor, sweep counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_FILL;
         row_ff      <= '0;
         col_ff      <= '0;
         row_base_ff <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
         rd_valid_ff <= 1'b0;
         scroll_ff   <= 1'b0;
         fill_ff     <= tcw_pkg::BLANK_CELL;
         strobe_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_opcode == tcw_pkg::OP_READ) begin
                  oob_ff   <= !in_range;
                  state_ff <= ST_READ;
               end else if (is_put) begin
                  row_ff      <= row_in;
                  col_ff      <= col_in;
                  row_base_ff <= row_base_in;
                  cell_ff     <= is_newline ? '0 : new_cell;
                  row_out_ff  <= tcw_pkg::ROW_OUT_W'(row_in);
                  col_out_ff  <= tcw_pkg::COL_OUT_W'(col_in);
                  scrolled_ff <= do_scroll;
                  if (do_scroll) begin
                     state_ff    <= ST_COPY;
                     src_ff      <= tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                     dst_ff      <= '0;
                     rd_valid_ff <= 1'b0;
                     scroll_ff   <= 1'b1;
                     fill_ff     <= tcw_pkg::make_cell(tcw_pkg::SPACE_CODE, text_color);
                  end else begin
                     strobe_ff <= 1'b1;
                  end
               end
            end
            ST_READ: begin
               cell_ff     <= oob_ff ? '0 : rd_data;
               row_out_ff  <= tcw_pkg::ROW_OUT_W'(row_ff);
               col_out_ff  <= tcw_pkg::COL_OUT_W'(col_ff);
               scrolled_ff <= 1'b0;
               strobe_ff   <= 1'b1;
               state_ff    <= ST_IDLE;
            end
            ST_COPY: begin
               // read one row down, write in the following cycle
               if (src_live) begin
                  src_ff <= src_ff + tcw_pkg::CNT_W'(1);
               end
               rd_valid_ff <= src_live;
               if (rd_valid_ff) begin
                  dst_ff <= dst_ff + tcw_pkg::CNT_W'(1);
                  if (dst_ff == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS - 1)) begin
                     state_ff <= ST_FILL;
                  end
               end
            end
            ST_FILL: begin
               dst_ff <= dst_ff + tcw_pkg::CNT_W'(1);
               if (dst_ff == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
                  state_ff  <= ST_IDLE;
                  strobe_ff <= scroll_ff;
                  scroll_ff <= 1'b0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_cell_entry        = cell_ff;
   assign rsp_cursor_row_out    = row_out_ff;
   assign rsp_cursor_column_out = col_out_ff;
   assign rsp_scrolled          = scrolled_ff;

   // checks
   `TCW_ASSERT_NEXT(a_put_result, clock, reset, is_put && !do_scroll, rsp_strobe, "put item without scroll gave no result next cycle")
   `TCW_ASSERT_NEXT2(a_read_result, clock, reset, accept && req_opcode == tcw_pkg::OP_READ, rsp_strobe, "read item gave no result two cycles later")
   `TCW_ASSERT_NOW(a_copy_bound, clock, reset, state_ff == ST_COPY && ram_req.wr_en, dst_ff < tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS), "scroll copy wrote into the last row")
   `TCW_ASSERT_NOW(a_row_base, clock, reset, 1'b1, 32'(row_base_ff) == 32'(row_ff) * 32'(tcw_pkg::COLUMNS), "row base out of step with cursor row")

endmodule

// ----- test/text_console_char_writer_test.sv -----
// Self-checking testbench for the text console character writer: puts, reads,
// newlines, line wrap, scrolling and the colour register over the APB port.
// Depends on tcw_pkg and the text_console_char_writer RTL.
`timescale 1ns / 100ps

module text_console_char_writer_test;

   // one result of the block, as seen on the rsp_ ports
   typedef struct packed {
      logic [tcw_pkg::CELL_W-1:0]    cell_entry;
      logic [tcw_pkg::ROW_OUT_W-1:0] row;
      logic [tcw_pkg::COL_OUT_W-1:0] col;
      logic                          scrolled;
   } console_result_type;

   localparam logic [tcw_pkg::REG_IDX_W-1:0] REG_OUT_OF_RANGE = tcw_pkg::REG_TEXT_COLOR + 1'b1;
   localparam int INDEX_MAX       = (1 << tcw_pkg::INDEX_W) - 1;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int PHASE_COUNT     = 6;
   localparam int PRINT_LIMIT     = 40;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_opcode = tcw_pkg::OP_PUT;
   logic [tcw_pkg::CHAR_W-1:0]    req_char_code = '0;
   logic [tcw_pkg::INDEX_W-1:0]   req_read_index = '0;
   logic                          rsp_strobe;
   logic [tcw_pkg::CELL_W-1:0]    rsp_cell_entry;
   logic [tcw_pkg::ROW_OUT_W-1:0] rsp_cursor_row_out;
   logic [tcw_pkg::COL_OUT_W-1:0] rsp_cursor_column_out;
   logic                          rsp_scrolled;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [tcw_pkg::CSR_AW-1:0]    paddr = '0;
   logic [tcw_pkg::CSR_DW-1:0]    pwdata = '0;
   logic [tcw_pkg::CSR_DW-1:0]    prdata;
   logic                          pready;

   // shadow of the screen, cursor and colour register
   logic [tcw_pkg::CELL_W-1:0]    screen_shadow [tcw_pkg::CELL_COUNT];
   int                            cursor_row_shadow;
   int                            cursor_col_shadow;
   logic [tcw_pkg::COLOR_W-1:0]   color_shadow;

   console_result_type            awaited_results [$];
   console_result_type            observed;
   console_result_type            wanted;
   int                            mismatch_count = 0;
   int                            items_sent = 0;
   bit                            sender_gaps = 1'b1;

   text_console_char_writer DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_char_code         (req_char_code),
      .req_read_index        (req_read_index),
      .rsp_strobe            (rsp_strobe),
      .rsp_cell_entry        (rsp_cell_entry),
      .rsp_cursor_row_out    (rsp_cursor_row_out),
      .rsp_cursor_column_out (rsp_cursor_column_out),
      .rsp_scrolled          (rsp_scrolled),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always #1 clock = ~clock;

   // safety net against a hung handshake
   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // cursor to column zero of the next row, scrolling from the last row
   function automatic logic shadow_next_line();
      cursor_col_shadow = 0;
      if (cursor_row_shadow + 1 < tcw_pkg::ROWS) begin
         cursor_row_shadow++;
         return 1'b0;
      end
      for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
         screen_shadow[i] = screen_shadow[i + tcw_pkg::COLUMNS];
      for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
         screen_shadow[i] = {color_shadow, tcw_pkg::SPACE_CODE};
      cursor_row_shadow = tcw_pkg::ROWS - 1;
      return 1'b1;
   endfunction

   // apply one item to the shadow console and return the cell and cursor
   function automatic console_result_type console_apply(
         input logic                        op,
         input logic [tcw_pkg::CHAR_W-1:0]  ch,
         input logic [tcw_pkg::INDEX_W-1:0] idx);
      console_result_type r;
      int                 pos;
      r.cell_entry = '0;
      r.scrolled = 1'b0;
      if (op == tcw_pkg::OP_READ) begin
         if (idx < tcw_pkg::CELL_COUNT)
            r.cell_entry = screen_shadow[idx];
      end else if (ch == tcw_pkg::NEWLINE_CODE) begin
         r.scrolled = shadow_next_line();
      end else begin
         pos = cursor_row_shadow * tcw_pkg::COLUMNS + cursor_col_shadow;
         r.cell_entry = {color_shadow, ch};
         screen_shadow[pos] = r.cell_entry;
         cursor_col_shadow++;
         if (cursor_col_shadow >= tcw_pkg::COLUMNS)
            r.scrolled = shadow_next_line();
      end
      r.row = tcw_pkg::ROW_OUT_W'(cursor_row_shadow);
      r.col = tcw_pkg::COL_OUT_W'(cursor_col_shadow);
      return r;
   endfunction

   // present one item, with random gaps while sender_gaps is set, and hold it until accepted
   task automatic send_item(input logic op, input logic [tcw_pkg::CHAR_W-1:0] ch,
                            input logic [tcw_pkg::INDEX_W-1:0] idx);
      @(negedge clock);
      while (sender_gaps && $urandom_range(0, 99) < 32) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_opcode = op;
      req_char_code = ch;
      req_read_index = idx;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      awaited_results.push_back(console_apply(op, ch, idx));
      items_sent++;
   endtask

   // drain outstanding results so the block is idle for a register write
   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [tcw_pkg::REG_IDX_W-1:0] idx,
                                 input logic [tcw_pkg::CSR_DW-1:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (idx == tcw_pkg::REG_TEXT_COLOR)
         color_shadow = value[tcw_pkg::COLOR_W-1:0];
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic check_register();
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = {tcw_pkg::REG_TEXT_COLOR, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (prdata[tcw_pkg::COLOR_W-1:0] !== color_shadow)
         report_mismatch($sformatf("text_color read %0h, expected %0h",
                                   prdata[tcw_pkg::COLOR_W-1:0], color_shadow));
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   // mostly on-screen cells, now and then past the end of the screen
   function automatic logic [tcw_pkg::INDEX_W-1:0] random_cell_index();
      if ($urandom_range(0, 99) < 8)
         return tcw_pkg::INDEX_W'($urandom_range(tcw_pkg::CELL_COUNT, INDEX_MAX));
      return tcw_pkg::INDEX_W'($urandom_range(0, tcw_pkg::CELL_COUNT - 1));
   endfunction

   // result checker: every strobe pairs with the oldest outstanding item
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         observed = {rsp_cell_entry, rsp_cursor_row_out, rsp_cursor_column_out,
                     rsp_scrolled};
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result %0h with no item outstanding",
                                      rsp_cell_entry));
         end else begin
            wanted = awaited_results.pop_front();
            if (observed.cell_entry !== wanted.cell_entry)
               report_mismatch($sformatf("cell_entry %0h, expected %0h",
                                         observed.cell_entry, wanted.cell_entry));
            if (observed.row !== wanted.row)
               report_mismatch($sformatf("cursor_row_out %0d, expected %0d",
                                         observed.row, wanted.row));
            if (observed.col !== wanted.col)
               report_mismatch($sformatf("cursor_column_out %0d, expected %0d",
                                         observed.col, wanted.col));
            if (observed.scrolled !== wanted.scrolled)
               report_mismatch($sformatf("scrolled %0b, expected %0b",
                                         observed.scrolled, wanted.scrolled));
         end
      end
   end

   // reset value, masking of the write data, writes to an unused address
   task automatic test_register_access();
      check_register();
      write_register(tcw_pkg::REG_TEXT_COLOR, {24'hA5A5A5, 8'h3C});
      check_register();
      write_register(REG_OUT_OF_RANGE, $urandom());
      check_register();
   endtask

   // lowest and highest character codes, read back from the screen
   task automatic test_put_extremes();
      send_item(tcw_pkg::OP_PUT, 8'h00, tcw_pkg::INDEX_W'(INDEX_MAX));
      send_item(tcw_pkg::OP_PUT, 8'hFF, '0);
      send_item(tcw_pkg::OP_READ, 8'hFF, tcw_pkg::INDEX_W'(0));
      send_item(tcw_pkg::OP_READ, tcw_pkg::NEWLINE_CODE, tcw_pkg::INDEX_W'(1));
   endtask

   // last cell, first index past the screen, all-ones index
   task automatic test_read_range();
      send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::INDEX_W'(tcw_pkg::CELL_COUNT - 1));
      send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::INDEX_W'(tcw_pkg::CELL_COUNT));
      send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::INDEX_W'(INDEX_MAX));
   endtask

   // newlines down to the last row, then one more scrolls in a new colour
   task automatic test_newline_scroll();
      while (cursor_row_shadow < tcw_pkg::ROWS - 1)
         send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, '0);
      wait_idle();
      write_register(tcw_pkg::REG_TEXT_COLOR, 32'h0000_001E);
      send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, '0);
      send_item(tcw_pkg::OP_READ, 8'h00,
                tcw_pkg::INDEX_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS));
      send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::INDEX_W'(0));
   endtask

   // lines of random text with reads mixed in, plus loose random items
   task automatic test_random_text();
      int                          phase_target;
      int                          line_len;
      logic [tcw_pkg::COLOR_W-1:0] color;
      logic [tcw_pkg::CHAR_W-1:0]  ch;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         case (phase)
            0: color = 8'h00;
            1: color = 8'hFF;
            default: color = tcw_pkg::COLOR_W'($urandom_range(0, 255));
         endcase
         write_register(tcw_pkg::REG_TEXT_COLOR,
                        {24'($urandom_range(0, 32'h00FF_FFFF)), color});
         if (phase % 2 == 1)
            write_register(REG_OUT_OF_RANGE, $urandom());
         check_register();
         // one phase runs back to back with no gaps
         sender_gaps = (phase != 2);
         phase_target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_target) begin
            if ($urandom_range(0, 99) < 75) begin
               if ($urandom_range(0, 99) < 12)
                  line_len = $urandom_range(tcw_pkg::COLUMNS - 5, tcw_pkg::COLUMNS + 10);
               else
                  line_len = $urandom_range(0, 30);
               for (int j = 0; j < line_len; j++) begin
                  if ($urandom_range(0, 99) < 15)
                     send_item(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                               random_cell_index());
                  ch = tcw_pkg::CHAR_W'($urandom_range(0, 255));
                  if (ch == tcw_pkg::NEWLINE_CODE)
                     ch = tcw_pkg::SPACE_CODE;
                  send_item(tcw_pkg::OP_PUT, ch,
                            tcw_pkg::INDEX_W'($urandom_range(0, INDEX_MAX)));
               end
               send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE,
                         tcw_pkg::INDEX_W'($urandom_range(0, INDEX_MAX)));
            end else begin
               send_item(1'($urandom_range(0, 1)), tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                         tcw_pkg::INDEX_W'($urandom_range(0, INDEX_MAX)));
            end
         end
      end
      sender_gaps = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
         screen_shadow[i] = tcw_pkg::BLANK_CELL;
      cursor_row_shadow = 0;
      cursor_col_shadow = 0;
      color_shadow = tcw_pkg::COLOR_RESET;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // let the clearing pass finish
      @(posedge clock);
      while (busy)
         @(posedge clock);

      test_register_access();
      test_put_extremes();
      test_read_range();
      test_newline_scroll();
      test_random_text();

      @(negedge clock);
      start = 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/tcw_pkg.sv
src/tcw_screen_ram.sv
src/tcw_csr.sv
src/tcw_engine.sv
src/text_console_char_writer.sv
test/text_console_char_writer_test.sv
